// File: hw/rtl/mflm_pkg.sv
`timescale 1ns / 1ps
package mflm_pkg;

   localparam int DEFAULT_PORT_COUNT  = 4;
   localparam int DEFAULT_QUEUE_DEPTH = 128;

   localparam int ADDR_W        = 48;
   localparam int TAG_W         = 16;
   localparam int TICK_W        = 32;
   localparam int DELAY_W       = 10;
   localparam int LIMIT_W       = 3;
   localparam int PORT_FIELD_W  = 2;
   // widest port index over the supported port counts
   localparam int PORT_IDX_W    = 4;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 10;
   localparam int CMD_DEPTH     = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_READ_DELAY = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPTS    = 1'd1;

   localparam logic [DELAY_W-1:0] READ_DELAY_RESET = 10'd80;
   localparam logic [LIMIT_W-1:0] ACCEPTS_RESET    = 3'd4;

   localparam logic REQ_TYPE_PORT = 1'b0;
   localparam logic REQ_TYPE_TICK = 1'b1;

   localparam logic [1:0] KIND_READ_RSP  = 2'd0;
   localparam logic [1:0] KIND_REJECT    = 2'd1;
   localparam logic [1:0] KIND_TICK_DONE = 2'd2;

   typedef struct packed {
      logic                    req_type;
      logic [PORT_FIELD_W-1:0] port;
      logic                    write_flag;
      logic [ADDR_W-1:0]       mem_addr;
      logic [TAG_W-1:0]        tag;
   } req_item_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [PORT_FIELD_W-1:0] dest_port;
      logic [ADDR_W-1:0]       resp_addr;
      logic [TAG_W-1:0]        resp_tag;
      logic                    idle;
      logic                    last;
   } rsp_item_type;

   // work handed from the front to the back
   typedef struct packed {
      logic                    is_tick;
      logic [PORT_FIELD_W-1:0] port;
      logic [TICK_W-1:0]       tick;
   } cmd_type;

   typedef struct packed {
      logic [PORT_IDX_W-1:0] port;
      logic [TICK_W-1:0]     due;
      logic [ADDR_W-1:0]     addr;
      logic [TAG_W-1:0]      tag;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic idle;
      logic full;
   } back_status_type;

endpackage

// File: hw/rtl/mflm_cmd_fifo.sv
`timescale 1ns / 1ps
module mflm_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mflm_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output mflm_pkg::cmd_type pop_data,
   output logic              empty
);
   import mflm_pkg::*;

   localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

   cmd_type          mem_ff [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == (PTR_W+1)'(CMD_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/mflm_front.sv
`timescale 1ns / 1ps
module mflm_front #(
   parameter int PORT_COUNT = mflm_pkg::DEFAULT_PORT_COUNT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  mflm_pkg::req_item_type                req_payload,
   input  logic [mflm_pkg::DELAY_W-1:0]          read_delay,
   input  logic [mflm_pkg::LIMIT_W-1:0]          accepts_per_tick,
   input  mflm_pkg::back_status_type             back_status,
   input  logic                                  cmd_full,
   input  logic                                  cmd_empty,
   output logic                                  cmd_push,
   output mflm_pkg::cmd_type                     cmd_data,
   output mflm_pkg::q_push_type                  q_push
);
   import mflm_pkg::*;

   localparam int PORT_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int CNT_W  = (PORT_W + 1 > LIMIT_W) ? PORT_W + 1 : LIMIT_W;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_WAIT = 2'd1;
   localparam logic [1:0] F_SCAN = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [PORT_COUNT-1:0] slot_valid_ff, slot_valid_in;
   logic [PORT_COUNT-1:0] slot_write_ff, slot_write_in;
   logic [ADDR_W-1:0]   slot_addr_ff [PORT_COUNT];
   logic [TAG_W-1:0]    slot_tag_ff  [PORT_COUNT];
   logic [PORT_W-1:0]   grant_ff, grant_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [PORT_W-1:0]   scan_ff, scan_in;
   logic [CNT_W-1:0]    taken_ff, taken_in;

   logic              accept;
   logic              port_in_range;
   logic [PORT_W-1:0] req_idx;
   logic              slot_fill;
   logic [PORT_W-1:0] visit;
   logic              visit_valid, visit_write;
   logic              take, push_read, stop;
   logic [CNT_W-1:0]  taken_next;

   assign req_ready     = (state_ff == F_IDLE) && !cmd_full;
   assign accept        = req_valid && req_ready;
   assign req_idx       = PORT_W'(req_payload.port);
   assign port_in_range = (int'(req_payload.port) < PORT_COUNT);
   assign slot_fill     = accept && (req_payload.req_type == REQ_TYPE_PORT) && port_in_range
                          && !slot_valid_ff[req_idx];

   // one round-robin visit per cycle
   assign visit       = (grant_ff == PORT_W'(PORT_COUNT - 1)) ? '0 : grant_ff + 1'b1;
   assign visit_valid = slot_valid_ff[visit];
   assign visit_write = slot_write_ff[visit];
   assign take        = visit_valid && (visit_write || !back_status.full);
   assign push_read   = visit_valid && !visit_write && !back_status.full;
   assign taken_next  = taken_ff + CNT_W'(take);
   // a limit of zero never matches, so it places no limit
   assign stop        = (take && (taken_next == CNT_W'(accepts_per_tick)))
                        || (scan_ff == PORT_W'(PORT_COUNT - 1));

   always_comb begin
      q_push.valid       = (state_ff == F_SCAN) && push_read;
      q_push.entry.port  = PORT_IDX_W'(visit);
      q_push.entry.due   = tick_ff + TICK_W'(read_delay);
      q_push.entry.addr  = slot_addr_ff[visit];
      q_push.entry.tag   = slot_tag_ff[visit];
   end

   always_comb begin
      state_in      = state_ff;
      slot_valid_in = slot_valid_ff;
      slot_write_in = slot_write_ff;
      grant_in      = grant_ff;
      tick_in       = tick_ff;
      scan_in       = scan_ff;
      taken_in      = taken_ff;
      cmd_push      = 1'b0;
      cmd_data      = '0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_payload.req_type == REQ_TYPE_TICK) begin
                  state_in = F_WAIT;
               end else if (port_in_range) begin
                  if (slot_valid_ff[req_idx]) begin
                     cmd_push      = 1'b1;
                     cmd_data.port = req_payload.port;
                  end else begin
                     slot_valid_in[req_idx] = 1'b1;
                     slot_write_in[req_idx] = req_payload.write_flag;
                  end
               end
            end
         end
         F_WAIT: begin
            // queue occupancy must be final before intake
            if (back_status.idle && cmd_empty) begin
               state_in = F_SCAN;
               scan_in  = '0;
               taken_in = '0;
            end
         end
         F_SCAN: begin
            grant_in = visit;
            scan_in  = scan_ff + 1'b1;
            taken_in = taken_next;
            if (take) begin
               slot_valid_in[visit] = 1'b0;
            end
            if (stop) begin
               cmd_push         = 1'b1;
               cmd_data.is_tick = 1'b1;
               cmd_data.tick    = tick_ff;
               tick_in          = tick_ff + 1'b1;
               state_in         = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         slot_valid_ff <= '0;
         slot_write_ff <= '0;
         grant_ff      <= PORT_W'(PORT_COUNT - 1);
         tick_ff       <= '0;
         scan_ff       <= '0;
         taken_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         slot_write_ff <= slot_write_in;
         grant_ff      <= grant_in;
         tick_ff       <= tick_in;
         scan_ff       <= scan_in;
         taken_ff      <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_fill) begin
         slot_addr_ff[req_idx] <= req_payload.mem_addr;
         slot_tag_ff[req_idx]  <= req_payload.tag;
      end
   end

endmodule

// File: hw/rtl/mflm_back.sv
`timescale 1ns / 1ps
module mflm_back #(
   parameter int PORT_COUNT  = mflm_pkg::DEFAULT_PORT_COUNT,
   parameter int QUEUE_DEPTH = mflm_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_empty,
   input  mflm_pkg::cmd_type         cmd_data,
   output logic                      cmd_pop,
   input  mflm_pkg::q_push_type      q_push,
   output mflm_pkg::back_status_type back_status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mflm_pkg::rsp_item_type    rsp_payload
);
   import mflm_pkg::*;

   localparam int PORT_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int QW     = $clog2(QUEUE_DEPTH);
   localparam int CW     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] B_IDLE  = 2'd0;
   localparam logic [1:0] B_READ  = 2'd1;
   localparam logic [1:0] B_CHECK = 2'd2;
   localparam logic [1:0] B_DONE  = 2'd3;

   q_entry_type          q_mem [QUEUE_DEPTH];
   q_entry_type          rd_data_ff;
   logic [1:0]           state_ff, state_in;
   logic [QW-1:0]        head_ff, head_in;
   logic [QW-1:0]        tail_ff, tail_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [TICK_W-1:0]    tick_now_ff, tick_now_in;
   logic [PORT_COUNT-1:0] sent_ff, sent_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_item_type         out_ff, out_in;

   logic              out_free, out_load;
   logic              rd_en, pop;
   logic [TICK_W-1:0] age;
   logic [PORT_W-1:0] head_port;
   logic              blocked;

   assign out_free    = !out_valid_ff || rsp_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   assign back_status.idle = (state_ff == B_IDLE);
   assign back_status.full = (count_ff == CW'(QUEUE_DEPTH));

   // wrapped difference; top bit set means not yet due
   assign age       = tick_now_ff - rd_data_ff.due;
   assign head_port = rd_data_ff.port[PORT_W-1:0];
   assign blocked   = age[TICK_W-1] || sent_ff[head_port];

   always_comb begin
      state_in    = state_ff;
      tick_now_in = tick_now_ff;
      sent_in     = sent_ff;
      out_in      = out_ff;
      out_load    = 1'b0;
      cmd_pop     = 1'b0;
      rd_en       = 1'b0;
      pop         = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_empty) begin
               if (cmd_data.is_tick) begin
                  cmd_pop     = 1'b1;
                  tick_now_in = cmd_data.tick;
                  sent_in     = '0;
                  state_in    = B_READ;
               end else if (out_free) begin
                  cmd_pop          = 1'b1;
                  out_load         = 1'b1;
                  out_in           = '0;
                  out_in.kind      = KIND_REJECT;
                  out_in.dest_port = cmd_data.port;
                  out_in.last      = 1'b1;
               end
            end
         end
         B_READ: begin
            if (count_ff == '0) begin
               state_in = B_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = B_CHECK;
            end
         end
         B_CHECK: begin
            if (blocked) begin
               state_in = B_DONE;
            end else if (out_free) begin
               out_load           = 1'b1;
               pop                = 1'b1;
               sent_in[head_port] = 1'b1;
               out_in             = '0;
               out_in.kind        = KIND_READ_RSP;
               out_in.dest_port   = rd_data_ff.port[PORT_FIELD_W-1:0];
               out_in.resp_addr   = rd_data_ff.addr;
               out_in.resp_tag    = rd_data_ff.tag;
               state_in           = B_READ;
            end
         end
         B_DONE: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_in      = '0;
               out_in.kind = KIND_TICK_DONE;
               out_in.idle = (count_ff == '0);
               out_in.last = 1'b1;
               state_in    = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (q_push.valid) begin
         tail_in = (tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (q_push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !q_push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sent_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         sent_ff      <= sent_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_now_ff <= tick_now_in;
      out_ff      <= out_in;
   end

   // read queue storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         q_mem[tail_ff] <= q_push.entry;
      end
      if (rd_en) begin
         rd_data_ff <= q_mem[head_ff];
      end
   end

endmodule

// File: hw/rtl/multiport_fixed_latency_memory.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_payload  (port request or tick)
// rsp      out        rsp_valid/rsp_ready    rsp_payload  (response, reject, tick done)
// csr      in         csr_wr_en              csr_index, csr_wr_data (write only)
//
// A port request is taken while the front is idle. A tick waits until the back end is
// idle and the command queue is empty, then visits one port per cycle, stopping after
// PORT_COUNT ports or at the accept limit. The back end picks up the tick, reads and checks
// the queue head per read response, and sends tick done once the queue is empty or blocked.
// Reset is synchronous and active high; the read queue needs no clearing pass.
// A stalled rsp channel holds the back end; the front keeps taking port requests until a
// tick arrives or rejects fill the two-entry command queue.
module multiport_fixed_latency_memory #(
   parameter int PORT_COUNT  = mflm_pkg::DEFAULT_PORT_COUNT,
   parameter int QUEUE_DEPTH = mflm_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mflm_pkg::req_item_type              req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mflm_pkg::rsp_item_type              rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [mflm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mflm_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import mflm_pkg::*;

   // configuration registers
   logic [DELAY_W-1:0] read_delay_ff;
   logic [LIMIT_W-1:0] accepts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         read_delay_ff <= READ_DELAY_RESET;
         accepts_ff    <= ACCEPTS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_READ_DELAY: read_delay_ff <= csr_wr_data[DELAY_W-1:0];
            CSR_ACCEPTS:    accepts_ff    <= csr_wr_data[LIMIT_W-1:0];
            default:        ;
         endcase
      end
   end

   // front-to-back links
   cmd_type         cmd_in_data, cmd_out_data;
   logic            cmd_push, cmd_pop, cmd_full, cmd_empty;
   q_push_type      q_push;
   back_status_type back_status;

   // front: slot intake and round-robin grant; also stamps read due times
   mflm_front #(
      .PORT_COUNT (PORT_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .read_delay       (read_delay_ff),
      .accepts_per_tick (accepts_ff),
      .back_status      (back_status),
      .cmd_full         (cmd_full),
      .cmd_empty        (cmd_empty),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_in_data),
      .q_push           (q_push)
   );

   // rejects and tick work, in arrival order
   mflm_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   // back: read queue, maturity check, result register
   mflm_back #(
      .PORT_COUNT  (PORT_COUNT),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (cmd_empty),
      .cmd_data    (cmd_out_data),
      .cmd_pop     (cmd_pop),
      .q_push      (q_push),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
